@@ sv/rgbhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_pkg - shared types and constants for the RGB to HSV converter
// Holds channel widths, the classified pixel record and the queue status.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int CH_W    = 8;   // one color channel
	localparam int DEN_W   = 11;  // holds six times the widest spread (1530)
	localparam int OUT_W   = 16;  // hue and saturation fields
	localparam int Q_DEPTH = 2;   // entries in the front-to-back queue

	// hue sector offsets, in units of the spread
	localparam int OFS_GREEN = 2;
	localparam int OFS_BLUE  = 4;
	localparam int OFS_WRAP  = 6;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// one pixel after classification, ready for the dividers
	typedef struct packed {
		logic [CH_W-1:0]  bright;   // largest channel
		logic [CH_W-1:0]  spread;   // max minus min
		logic [DEN_W-1:0] hue_num;  // offset * spread + sector numerator
		logic [DEN_W-1:0] hue_den;  // six times the spread
		logic             grey;     // spread is zero
		logic             full;     // min is zero on a nonblack pixel: saturation hits the top code
	} pix_class_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ sv/rgb_to_hsv_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter - 8-bit RGB pixel to fixed-point HSV
// Throughput: one pixel per clock; busy stays low while the dividers flow.
// Path: a taken pixel passes the intake register, the queue entry, the
// one-bit-per-stage divider pipelines and the output register before
// its result beat is taken.
// Reset: arst_n clears all valid bits and queue pointers at once; no sweep.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter import rgbhsv_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CH_W-1:0]  red,
	input  logic [CH_W-1:0]  green,
	input  logic [CH_W-1:0]  blue,
	output logic             busy,
	output logic             done,
	output logic [OUT_W-1:0] hue,
	output logic [OUT_W-1:0] saturation,
	output logic [CH_W-1:0]  brightness
);

	localparam int LATENCY = FRACTION_BITS + 3;

	logic       push;
	logic       pop;
	pix_class_t front_item;
	pix_class_t back_item;
	q_stat_t    q_stat;

	// Front end: take a pixel beat, find max/min/sector, hold it until the
	// queue has room. busy only rises if the queue backs up.
	rgbhsv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.q_stat (q_stat),
		.busy   (busy),
		.push   (push),
		.item   (front_item)
	);

	// Queue: parts intake from arithmetic so each side advances on its own.
	rgbhsv_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_item),
		.pop    (pop),
		.dout   (back_item),
		.q_stat (q_stat)
	);

	// Back end never stalls, so drain the queue whenever it holds a beat.
	assign pop = !q_stat.empty;

	// Back end: two divider pipelines, clamp, and the output register that
	// drives the one-cycle result strobe.
	rgbhsv_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pop),
		.item       (back_item),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	// Every taken pixel must produce its done beat LATENCY later.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result beat missing at fixed latency");

	// Black pixel: hue and saturation both zero.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && brightness == '0) |-> (saturation == '0 && hue == '0))
		else $error("black pixel with nonzero hue or saturation");

	// Nonzero hue needs a nonzero spread, hence nonzero saturation.
	a_hue_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hue != '0) |-> (saturation != '0))
		else $error("nonzero hue on a pixel with zero saturation");

endmodule

@@ sv/rgbhsv_front.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_front - pixel intake and classification
// Finds max, min and sector, forms the hue numerator and denominator.
// ----------------------------------------------------------------------------
module rgbhsv_front import rgbhsv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	input  q_stat_t         q_stat,
	output logic            busy,
	output logic            push,
	output pix_class_t      item
);

	logic             vld_s1;
	pix_class_t       item_s1;
	logic             accept;
	sector_t          sector;
	logic [CH_W-1:0]  mx;
	logic [CH_W-1:0]  mn;
	logic [CH_W-1:0]  d;
	logic [DEN_W-1:0] d_w;
	logic [DEN_W-1:0] r_w;
	logic [DEN_W-1:0] g_w;
	logic [DEN_W-1:0] b_w;
	logic [DEN_W-1:0] den6;
	logic [DEN_W-1:0] num;

	assign push   = vld_s1 && !q_stat.full;
	assign busy   = vld_s1 && q_stat.full;
	assign accept = start && !busy;
	assign item   = item_s1;

	// ties go to red, then green
	always_comb begin
		if (red >= green && red >= blue) begin
			sector = SECT_RED;
		end else if (green >= blue) begin
			sector = SECT_GREEN;
		end else begin
			sector = SECT_BLUE;
		end
	end

	always_comb begin
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
	end

	always_comb begin
		case (sector)
			SECT_RED:   mx = red;
			SECT_GREEN: mx = green;
			SECT_BLUE:  mx = blue;
			default:    mx = red;
		endcase
	end

	assign d    = mx - mn;
	assign d_w  = DEN_W'(d);
	assign r_w  = DEN_W'(red);
	assign g_w  = DEN_W'(green);
	assign b_w  = DEN_W'(blue);
	assign den6 = DEN_W'(d_w * DEN_W'(OFS_WRAP));

	// sums stay in range, so modular arithmetic gives the true value
	always_comb begin
		case (sector)
			SECT_RED: begin
				if (green >= blue) begin
					num = g_w - b_w;
				end else begin
					num = den6 + g_w - b_w;
				end
			end
			SECT_GREEN: num = DEN_W'(d_w * DEN_W'(OFS_GREEN)) + b_w - r_w;
			SECT_BLUE:  num = DEN_W'(d_w * DEN_W'(OFS_BLUE)) + r_w - g_w;
			default:    num = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.bright  <= mx;
			item_s1.spread  <= d;
			item_s1.hue_num <= num;
			item_s1.hue_den <= den6;
			item_s1.grey    <= (d == '0);
			item_s1.full    <= (mn == '0) && (mx != '0);
		end
	end

endmodule

@@ sv/rgbhsv_fifo.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_fifo - short queue between intake and arithmetic
// Decouples the classifier from the divider pipelines.
// ----------------------------------------------------------------------------
module rgbhsv_fifo import rgbhsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pix_class_t din,
	input  logic       pop,
	output pix_class_t dout,
	output q_stat_t    q_stat
);

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	pix_class_t       entry_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full  = (cnt_q == CNT_W'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign dout         = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ sv/rgbhsv_div.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_div - pipelined restoring divider
// Computes (num << QBITS) / den for num < den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgbhsv_div #(
	parameter int QBITS = 16,
	parameter int DW    = 11,
	parameter int TW    = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [DW-1:0]    num,
	input  logic [DW-1:0]    den,
	input  logic [TW-1:0]    tag,
	output logic             out_valid,
	output logic [QBITS-1:0] quo,
	output logic [TW-1:0]    out_tag
);

	logic             vld_s [1:QBITS];
	logic [QBITS-1:0] quo_s [1:QBITS];
	logic [TW-1:0]    tag_s [1:QBITS];
	logic [DW-1:0]    rem_s [1:QBITS-1];
	logic [DW-1:0]    den_s [1:QBITS-1];

	for (genvar k = 1; k <= QBITS; k++) begin : g_stage
		logic             vld_in;
		logic [DW-1:0]    rem_in;
		logic [DW-1:0]    den_in;
		logic [QBITS-1:0] quo_in;
		logic [TW-1:0]    tag_in;
		logic [DW:0]      rem2;
		logic [DW:0]      diff;
		logic             ge;

		if (k == 1) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
			assign tag_in = tag;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		assign rem2 = {rem_in, 1'b0};
		assign diff = rem2 - {1'b0, den_in};
		assign ge   = (rem2 >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			quo_s[k] <= {quo_in[QBITS-2:0], ge};
			tag_s[k] <= tag_in;
		end

		// last stage needs no remainder
		if (k < QBITS) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? diff[DW-1:0] : rem2[DW-1:0];
				den_s[k] <= den_in;
			end
		end
	end

	assign out_valid = vld_s[QBITS];
	assign quo       = quo_s[QBITS];
	assign out_tag   = tag_s[QBITS];

endmodule

@@ sv/rgbhsv_back.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_back - arithmetic back end
// Runs hue and saturation dividers side by side and registers the result.
// ----------------------------------------------------------------------------
module rgbhsv_back import rgbhsv_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  pix_class_t       item,
	output logic             done,
	output logic [OUT_W-1:0] hue,
	output logic [OUT_W-1:0] saturation,
	output logic [CH_W-1:0]  brightness
);

	localparam int CW = (FRACTION_BITS > OUT_W) ? FRACTION_BITS : OUT_W;
	localparam logic [CW-1:0] TOP_CODE = CW'((64'd1 << FRACTION_BITS) - 64'd1);
	localparam logic [CW-1:0] LIM =
		(FRACTION_BITS > OUT_W) ? CW'({OUT_W{1'b1}}) : TOP_CODE;

	logic                     sat_vld;
	logic                     hue_vld;
	logic [FRACTION_BITS-1:0] sat_quo;
	logic [FRACTION_BITS-1:0] hue_quo;
	logic [CH_W:0]            sat_tag;
	logic                     hue_grey;
	logic [CH_W-1:0]          bright;
	logic                     full;
	logic [CW-1:0]            sq;
	logic [CW-1:0]            hq;
	logic [CW-1:0]            sat_c;
	logic [CW-1:0]            hue_c;
	logic                     done_q;
	logic [OUT_W-1:0]         hue_q;
	logic [OUT_W-1:0]         sat_q;
	logic [CH_W-1:0]          bright_q;

	rgbhsv_div #(
		.QBITS (FRACTION_BITS),
		.DW    (CH_W),
		.TW    (CH_W + 1)
	) u_sat_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.num       (item.spread),
		.den       (item.bright),
		.tag       ({item.bright, item.full}),
		.out_valid (sat_vld),
		.quo       (sat_quo),
		.out_tag   (sat_tag)
	);

	rgbhsv_div #(
		.QBITS (FRACTION_BITS),
		.DW    (DEN_W),
		.TW    (1)
	) u_hue_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.num       (item.hue_num),
		.den       (item.hue_den),
		.tag       (item.grey),
		.out_valid (hue_vld),
		.quo       (hue_quo),
		.out_tag   (hue_grey)
	);

	assign bright = sat_tag[CH_W:1];
	assign full   = sat_tag[0];
	assign sq     = CW'(sat_quo);
	assign hq     = CW'(hue_quo);

	// black reads zero; full spread, or a quotient above LIM, pins to LIM
	always_comb begin
		if (bright == '0) begin
			sat_c = '0;
		end else if (full || sq > LIM) begin
			sat_c = LIM;
		end else begin
			sat_c = sq;
		end
	end

	always_comb begin
		if (hue_grey) begin
			hue_c = '0;
		end else if (hq > LIM) begin
			hue_c = LIM;
		end else begin
			hue_c = hq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sat_vld && hue_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (sat_vld) begin
			hue_q    <= hue_c[OUT_W-1:0];
			sat_q    <= sat_c[OUT_W-1:0];
			bright_q <= bright;
		end
	end

	assign done       = done_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;

endmodule
